// File: hdl/crng_pkg.sv
// Package for the counter-based random block generator.
// Holds widths, algorithm constants, register indexes, the stage type and helpers.
// No dependencies; compile first.
`default_nettype none

package crng_pkg;

  localparam int COUNTER_W = 64;
  localparam int OFFSET_W  = 32;
  localparam int WORD_W    = 32;
  localparam int COUNT_W   = 3;
  localparam int KEY_W     = 64;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 64;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY       = CFG_IDX_W'(1);

  // Algorithm select codes
  localparam logic ALG_PHILOX   = 1'b0;
  localparam logic ALG_THREEFRY = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_PHILOX   = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_THREEFRY = COUNT_W'(2);

  localparam logic [WORD_W-1:0] MUL_A     = 32'hD2511F53;
  localparam logic [WORD_W-1:0] MUL_B     = 32'hCD9E8D57;
  localparam logic [WORD_W-1:0] WEYL_A    = 32'h9E3779B9;
  localparam logic [WORD_W-1:0] WEYL_B    = 32'hBB67AE85;
  localparam logic [WORD_W-1:0] TF_PARITY = 32'h1BD11BDA;

  // One pipeline stage per Philox round; Threefry does two rounds per stage
  localparam int NUM_STAGES = 10;

  localparam int TF_ROT [8] = '{13, 15, 26, 6, 17, 29, 16, 24};

  typedef struct packed {
    logic                   threefry;
    logic [3:0][WORD_W-1:0] w;
  } crng_stage_t;

  // Rotate left by a constant amount in 1..31
  function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v, input int r);
    rotl32 = (v << r) | (v >> (WORD_W - r));
  endfunction

  // Threefry key schedule word
  function automatic logic [WORD_W-1:0] tf_ks(input int idx,
                                              input logic [WORD_W-1:0] ka,
                                              input logic [WORD_W-1:0] kb);
    case (idx)
      0: tf_ks = ka;
      1: tf_ks = kb;
      default: tf_ks = TF_PARITY ^ ka ^ kb;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: hdl/crng_in_if.sv
// Input channel interface: valid/ready handshake carrying base counter and offset.
// Depends on crng_pkg.
`default_nettype none

interface crng_in_if;
  import crng_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [COUNTER_W-1:0] base_counter;
  logic [OFFSET_W-1:0]  block_offset;

  modport source (output valid, output base_counter, output block_offset, input ready);
  modport sink   (input valid, input base_counter, input block_offset, output ready);
endinterface

`default_nettype wire

// File: hdl/crng_out_if.sv
// Output channel interface: valid/ready handshake carrying one random block.
// Depends on crng_pkg.
`default_nettype none

interface crng_out_if;
  import crng_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  word0;
  logic [WORD_W-1:0]  word1;
  logic [WORD_W-1:0]  word2;
  logic [WORD_W-1:0]  word3;
  logic [COUNT_W-1:0] word_count;

  modport source (output valid, output word0, output word1, output word2, output word3,
                  output word_count, input ready);
  modport sink   (input valid, input word0, input word1, input word2, input word3,
                  input word_count, output ready);
endinterface

`default_nettype wire

// File: hdl/counter_rng_block_top.sv
// Top level of the counter-based random block generator (Philox4x32-10 and
// Threefry2x32-20). Depends on crng_pkg, crng_in_if, crng_out_if, crng_prep, crng_round.
//
// Usage:
//   req  (sink):   base_counter and block_offset; an item is taken when valid & ready.
//   rsp  (source): word0..word3 and word_count; one result item per request item.
//   cfg:           cfg_write/cfg_index/cfg_data write port. Index REG_ALGORITHM
//                  (bit 0: 0 Philox, 1 Threefry) and REG_KEY (64-bit key). Other
//                  indexes are ignored. Write only while the pipeline is empty.
// Pipeline: one entry stage (counter add, key carry, first Threefry injection)
//   and ten round stages, one Philox round or two Threefry rounds each, one
//   32x32 multiplier pair per stage. The last round register is the output.
// Throughput: one item per cycle; all stages advance together whenever the
//   output is empty or taken.
// Stall: when rsp.valid is high and rsp.ready low, every stage holds and
//   req.ready drops; nothing is lost or repeated.
// Reset (rst, synchronous): clears stage valid bits, algorithm and key to 0.
// In Threefry mode word2 and word3 are driven to zero and word_count is 2.
`default_nettype none

module counter_rng_block_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  crng_in_if.sink                             req,
  crng_out_if.source                          rsp,
  input  wire logic                           cfg_write,
  input  wire logic [crng_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crng_pkg::CFG_DATA_W-1:0] cfg_data
);
  import crng_pkg::*;

  logic             algorithm;
  logic [KEY_W-1:0] key;
  logic             advance;

  logic [NUM_STAGES:0] stage_valid;
  crng_stage_t         stage_data [NUM_STAGES+1];

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      algorithm <= ALG_PHILOX;
      key       <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ALGORITHM: algorithm <= cfg_data[0];
        REG_KEY:       key       <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished item waits at the output
  assign advance   = !stage_valid[NUM_STAGES] || rsp.ready;
  assign req.ready = advance;

  crng_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .in_valid     (req.valid),
    .base_counter (req.base_counter),
    .block_offset (req.block_offset),
    .algorithm    (algorithm),
    .key          (key),
    .out_valid    (stage_valid[0]),
    .out_data     (stage_data[0])
  );

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_round
    crng_round #(
      .ROUND (g)
    ) u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (stage_valid[g]),
      .in_data   (stage_data[g]),
      .key       (key),
      .out_valid (stage_valid[g+1]),
      .out_data  (stage_data[g+1])
    );
  end

  // Output fields straight from the last round register
  assign rsp.valid      = stage_valid[NUM_STAGES];
  assign rsp.word0      = stage_data[NUM_STAGES].w[0];
  assign rsp.word1      = stage_data[NUM_STAGES].w[1];
  assign rsp.word2      = stage_data[NUM_STAGES].w[2];
  assign rsp.word3      = stage_data[NUM_STAGES].w[3];
  assign rsp.word_count = (stage_data[NUM_STAGES].threefry == ALG_THREEFRY) ?
                          COUNT_THREEFRY : COUNT_PHILOX;

endmodule

`default_nettype wire

// File: hdl/crng_prep.sv
// Entry stage: forms the block counter, the Philox key-carry words and the
// initial Threefry key injection, then registers them. Depends on crng_pkg.
`default_nettype none

module crng_prep (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          advance,
  input  wire logic                          in_valid,
  input  wire logic [crng_pkg::COUNTER_W-1:0] base_counter,
  input  wire logic [crng_pkg::OFFSET_W-1:0]  block_offset,
  input  wire logic                          algorithm,
  input  wire logic [crng_pkg::KEY_W-1:0]     key,
  output logic                               out_valid,
  output crng_pkg::crng_stage_t              out_data
);
  import crng_pkg::*;

  logic [COUNTER_W:0]   ctr_sum;
  logic [KEY_W-1:0]     key_carry;
  crng_stage_t          stage_next;
  logic                 stage_valid;
  crng_stage_t          stage_data;

  always_comb begin
    ctr_sum   = {1'b0, base_counter} + {(COUNTER_W + 1 - OFFSET_W)'(0), block_offset};
    // Wrap past 2^64 bumps the key used as the upper Philox words
    key_carry = key + {(KEY_W - 1)'(0), ctr_sum[COUNTER_W]};
    stage_next.threefry = algorithm;
    if (algorithm == ALG_THREEFRY) begin
      stage_next.w[0] = ctr_sum[WORD_W-1:0] + key[WORD_W-1:0];
      stage_next.w[1] = ctr_sum[2*WORD_W-1:WORD_W] + key[2*WORD_W-1:WORD_W];
      stage_next.w[2] = '0;
      stage_next.w[3] = '0;
    end else begin
      stage_next.w[0] = ctr_sum[WORD_W-1:0];
      stage_next.w[1] = ctr_sum[2*WORD_W-1:WORD_W];
      stage_next.w[2] = key_carry[WORD_W-1:0];
      stage_next.w[3] = key_carry[2*WORD_W-1:WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_data <= stage_next;
    end
  end

  assign out_valid = stage_valid;
  assign out_data  = stage_data;

endmodule

`default_nettype wire

// File: hdl/crng_round.sv
// One round stage: a Philox4x32 round or two Threefry2x32 rounds (with key
// injection after odd stages), registered. Depends on crng_pkg.
`default_nettype none

module crng_round #(
  parameter int ROUND = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic                      in_valid,
  input  wire crng_pkg::crng_stage_t     in_data,
  input  wire logic [crng_pkg::KEY_W-1:0] key,
  output logic                           out_valid,
  output crng_pkg::crng_stage_t          out_data
);
  import crng_pkg::*;

  // Philox key words advance by the Weyl constants once per round
  localparam logic [2*WORD_W-1:0] WA_PROD = (2*WORD_W)'(ROUND) * (2*WORD_W)'(WEYL_A);
  localparam logic [2*WORD_W-1:0] WB_PROD = (2*WORD_W)'(ROUND) * (2*WORD_W)'(WEYL_B);
  localparam logic [WORD_W-1:0]   WA_OFF  = WA_PROD[WORD_W-1:0];
  localparam logic [WORD_W-1:0]   WB_OFF  = WB_PROD[WORD_W-1:0];

  // Threefry: four rounds per group, two per stage
  localparam int GROUP  = ROUND / 2;
  localparam int SUB    = ROUND % 2;
  localparam int ROT_A  = TF_ROT[(GROUP % 2) * 4 + SUB * 2];
  localparam int ROT_B  = TF_ROT[(GROUP % 2) * 4 + SUB * 2 + 1];
  localparam bit INJECT = (SUB == 1);
  localparam int INJ    = GROUP + 1;
  localparam logic [WORD_W-1:0] INJ_WORD = WORD_W'(INJ);

  logic [WORD_W-1:0]   ka;
  logic [WORD_W-1:0]   kb;
  logic [2*WORD_W-1:0] pa;
  logic [2*WORD_W-1:0] pb;
  logic [WORD_W-1:0]   x1, y1, x2, y2;
  crng_stage_t         stage_next;
  logic                stage_valid;
  crng_stage_t         stage_data;

  always_comb begin
    ka = key[WORD_W-1:0] + WA_OFF;
    kb = key[2*WORD_W-1:WORD_W] + WB_OFF;
    pa = {(WORD_W)'(0), in_data.w[0]} * {(WORD_W)'(0), MUL_A};
    pb = {(WORD_W)'(0), in_data.w[2]} * {(WORD_W)'(0), MUL_B};

    x1 = in_data.w[0] + in_data.w[1];
    y1 = rotl32(in_data.w[1], ROT_A) ^ x1;
    x2 = x1 + y1;
    y2 = rotl32(y1, ROT_B) ^ x2;

    stage_next.threefry = in_data.threefry;
    if (in_data.threefry == ALG_THREEFRY) begin
      if (INJECT) begin
        stage_next.w[0] = x2 + tf_ks(INJ % 3, key[WORD_W-1:0], key[2*WORD_W-1:WORD_W]);
        stage_next.w[1] = y2 + tf_ks((INJ + 1) % 3, key[WORD_W-1:0],
                                     key[2*WORD_W-1:WORD_W]) + INJ_WORD;
      end else begin
        stage_next.w[0] = x2;
        stage_next.w[1] = y2;
      end
      stage_next.w[2] = '0;
      stage_next.w[3] = '0;
    end else begin
      stage_next.w[0] = pb[2*WORD_W-1:WORD_W] ^ in_data.w[1] ^ key[WORD_W-1:0] ^ '0 ^ ka
                        ^ key[WORD_W-1:0];
      stage_next.w[1] = pb[WORD_W-1:0];
      stage_next.w[2] = pa[2*WORD_W-1:WORD_W] ^ in_data.w[3] ^ kb;
      stage_next.w[3] = pa[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_data <= stage_next;
    end
  end

  assign out_valid = stage_valid;
  assign out_data  = stage_data;

endmodule

`default_nettype wire
